// File: design/assert_macros.svh
// Assertion macros shared by the stopwatch RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is ignored while the reset is held.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked on every edge.
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

// File: design/swc_pkg.sv
// Types, constants and the segment decoder of the stopwatch.
// Depends on nothing; used by the top level, swc_timer and swc_display.
package swc_pkg;

    // Divider top after reset.
    localparam logic [15:0] CMP_RESET = 16'd62500;
    // Decimal point bit of the segment pattern.
    localparam logic [7:0] DP_BIT = 8'b1000_0000;
    // Scan position of the digit that shows the decimal point.
    localparam logic [1:0] SCAN_DP_POS = 2'd1;
    // Scan positions of the three leading digits; the seconds ones digit takes the last.
    localparam logic [1:0] SCAN_MIN_TENS = 2'd0;
    localparam logic [1:0] SCAN_MIN_ONES = 2'd1;
    localparam logic [1:0] SCAN_SEC_TENS = 2'd2;

    // What the counter hands to the display stage for one item.
    typedef struct packed {
        logic [3:0] digit;
        logic [1:0] scan_pos;
        logic       running;
    } t_disp_req;

    // Seven-segment pattern (a..g in bits 0..6) of one BCD digit.
    function automatic logic [7:0] seg_decode(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'b0011_1111;
            4'd1: seg = 8'b0000_0110;
            4'd2: seg = 8'b0101_1011;
            4'd3: seg = 8'b0100_1111;
            4'd4: seg = 8'b0110_0110;
            4'd5: seg = 8'b0110_1101;
            4'd6: seg = 8'b0111_1101;
            4'd7: seg = 8'b0000_0111;
            4'd8: seg = 8'b0111_1111;
            4'd9: seg = 8'b0110_1111;
            default: seg = 8'b0000_0000;
        endcase
        return seg;
    endfunction

endpackage

// File: design/swc_in_if.sv
// Input channel of the stopwatch: one clock sample per item.
// Depends on nothing.
interface swc_in_if;
    logic valid;
    logic ready;
    logic timer_tick;
    logic scan_step;
    logic start_pin;
    logic reset_pin;

    modport source (output valid, timer_tick, scan_step, start_pin, reset_pin,
                    input ready);
    modport sink   (input valid, timer_tick, scan_step, start_pin, reset_pin,
                    output ready);
endinterface

// File: design/swc_out_if.sv
// Result channel of the stopwatch: one scanned digit per item.
// Depends on nothing.
interface swc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [3:0] digit_enable_n;
    logic       running_led;

    modport source (output valid, segments, digit_enable_n, running_led, input ready);
    modport sink   (input valid, segments, digit_enable_n, running_led, output ready);
endinterface

// File: design/stopwatch_with_segment_scan.sv
// Top level of the mm:ss stopwatch with a four-digit multiplexed display.
// Depends on swc_pkg, swc_in_if, swc_out_if, swc_timer and swc_display.
//
// Usage: each input item is one clock sample holding a timer tick, a scan
// step and the two active-low button levels. For every item one result
// comes out: the segment pattern of the current scan digit (decimal point on
// the second digit), the active-low digit enables and the running LED.
// Write the divider top through i_cfg_wr_en / i_cfg_wr_data only while idle
// (unenforced); one second passes every compare value plus one running ticks.
// Latency: a result is valid the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver takes results; the count
// update and the segment decode each take one pass of logic between the state
// registers and the result register.
// Stall: while the receiver holds ready low, the result register keeps its
// item and the input side is not ready; an item is still taken in the cycle
// the waiting result leaves.
// Reset: the count reads 00:00, the watch is stopped, the scan is on the
// leftmost digit, the divider top is 62500 and no result is pending.
module stopwatch_with_segment_scan (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data,
    swc_in_if.sink       i_item,
    swc_out_if.source    o_result
);

    swc_pkg::t_disp_req req;
    logic               can_load;
    logic               accept;

    // An item is taken when it is offered and the result register has room.
    assign i_item.ready = can_load;
    assign accept       = i_item.valid && can_load;

    swc_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_tick        (i_item.timer_tick),
        .i_step        (i_item.scan_step),
        .i_start_pin   (i_item.start_pin),
        .i_reset_pin   (i_item.reset_pin),
        .o_req         (req)
    );

    swc_display u_display (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (i_item.valid),
        .i_req            (req),
        .i_out_ready      (o_result.ready),
        .o_can_load       (can_load),
        .o_valid          (o_result.valid),
        .o_segments       (o_result.segments),
        .o_digit_enable_n (o_result.digit_enable_n),
        .o_running_led    (o_result.running_led)
    );

endmodule

// File: design/swc_timer.sv
// Divider, BCD mm:ss count, button latches and scan position of the stopwatch.
// Depends on swc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module swc_timer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [15:0]          i_cfg_wr_data,
    input  logic                 i_accept,
    input  logic                 i_tick,
    input  logic                 i_step,
    input  logic                 i_start_pin,
    input  logic                 i_reset_pin,
    output swc_pkg::t_disp_req   o_req
);

    logic [15:0] r_cmp;
    logic [15:0] r_div,      n_div;
    logic [3:0]  r_sec_ones, n_sec_ones, t_sec_ones;
    logic [2:0]  r_sec_tens, n_sec_tens, t_sec_tens;
    logic [3:0]  r_min_ones, n_min_ones, t_min_ones;
    logic [3:0]  r_min_tens, n_min_tens, t_min_tens;
    logic        r_running,  n_running;
    logic        r_start_lat, n_start_lat;
    logic        r_reset_lat, n_reset_lat;
    logic [1:0]  r_scan,     n_scan;
    logic        run_tick;
    logic        adv_sec;

    // Divider and one-second advance of the BCD count.
    always_comb begin
        run_tick   = r_running & i_tick;
        adv_sec    = run_tick & (r_div == r_cmp);
        t_sec_ones = r_sec_ones;
        t_sec_tens = r_sec_tens;
        t_min_ones = r_min_ones;
        t_min_tens = r_min_tens;
        if (adv_sec) begin
            n_div = '0;
        end else if (run_tick) begin
            n_div = r_div + 16'd1;
        end else begin
            n_div = r_div;
        end
        if (adv_sec) begin
            if (r_sec_ones < 4'd9) begin
                t_sec_ones = r_sec_ones + 4'd1;
            end else begin
                t_sec_ones = '0;
                if (r_sec_tens < 3'd5) begin
                    t_sec_tens = r_sec_tens + 3'd1;
                end else begin
                    t_sec_tens = '0;
                    if (r_min_ones < 4'd9) begin
                        t_min_ones = r_min_ones + 4'd1;
                    end else begin
                        t_min_ones = '0;
                        if (r_min_tens < 4'd9) begin
                            t_min_tens = r_min_tens + 4'd1;
                        end else begin
                            t_min_tens = '0;
                        end
                    end
                end
            end
        end
    end

    // Buttons act after the tick; the scan moves on after the output.
    always_comb begin
        n_sec_ones  = t_sec_ones;
        n_sec_tens  = t_sec_tens;
        n_min_ones  = t_min_ones;
        n_min_tens  = t_min_tens;
        n_running   = r_running;
        n_start_lat = r_start_lat;
        n_reset_lat = r_reset_lat;
        n_scan      = i_step ? r_scan + 2'd1 : r_scan;
        if (!i_start_pin || !i_reset_pin) begin
            if (!r_start_lat && !r_reset_lat) begin
                if (!i_start_pin) begin
                    n_start_lat = 1'b1;
                    n_running   = ~r_running;
                end
                if (!i_reset_pin) begin
                    n_reset_lat = 1'b1;
                    n_sec_ones  = '0;
                    n_sec_tens  = '0;
                    n_min_ones  = '0;
                    n_min_tens  = '0;
                end
            end
        end else begin
            n_start_lat = 1'b0;
            n_reset_lat = 1'b0;
        end
    end

    // Digit shown for this item, taken from the count after the tick.
    always_comb begin
        case (r_scan)
            swc_pkg::SCAN_MIN_TENS: o_req.digit = t_min_tens;
            swc_pkg::SCAN_MIN_ONES: o_req.digit = t_min_ones;
            swc_pkg::SCAN_SEC_TENS: o_req.digit = {1'b0, t_sec_tens};
            default:                o_req.digit = t_sec_ones;
        endcase
        o_req.scan_pos = r_scan;
        o_req.running  = r_running;
    end

    // Compare register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp <= swc_pkg::CMP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cmp <= i_cfg_wr_data;
        end
    end

    // State update on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= '0;
            r_sec_ones  <= '0;
            r_sec_tens  <= '0;
            r_min_ones  <= '0;
            r_min_tens  <= '0;
            r_running   <= 1'b0;
            r_start_lat <= 1'b0;
            r_reset_lat <= 1'b0;
            r_scan      <= '0;
        end else if (i_accept) begin
            r_div       <= n_div;
            r_sec_ones  <= n_sec_ones;
            r_sec_tens  <= n_sec_tens;
            r_min_ones  <= n_min_ones;
            r_min_tens  <= n_min_tens;
            r_running   <= n_running;
            r_start_lat <= n_start_lat;
            r_reset_lat <= n_reset_lat;
            r_scan      <= n_scan;
        end
    end

    `ASSERT_RST(a_bcd_range, i_clk, i_rst_n, (r_sec_ones <= 4'd9) && (r_sec_tens <= 3'd5) && (r_min_ones <= 4'd9) && (r_min_tens <= 4'd9), "count left BCD range")
    `ASSERT_RST(a_div_wrap, i_clk, i_rst_n, i_accept && adv_sec |=> (r_div == 16'd0), "divider not cleared on second")
    `ASSERT_RST(a_run_hold, i_clk, i_rst_n, !i_accept |=> $stable(r_running) && $stable(r_div), "state moved without an item")

endmodule

// File: design/swc_display.sv
// Segment decode and result register of the stopwatch display.
// Depends on swc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module swc_display (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  swc_pkg::t_disp_req i_req,
    input  logic               i_out_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output logic [7:0]         o_segments,
    output logic [3:0]         o_digit_enable_n,
    output logic               o_running_led
);

    logic       r_valid;
    logic [7:0] r_seg,  n_seg;
    logic [3:0] r_den,  n_den;
    logic       r_led;

    // The register takes a new item whenever it is empty or being emptied.
    assign o_can_load = !r_valid || i_out_ready;

    // Decode of the selected digit and its enable.
    always_comb begin
        n_seg = swc_pkg::seg_decode(i_req.digit);
        if (i_req.scan_pos == swc_pkg::SCAN_DP_POS) begin
            n_seg = n_seg | swc_pkg::DP_BIT;
        end
        n_den = ~(4'b0001 << i_req.scan_pos);
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_seg <= n_seg;
            r_den <= n_den;
            r_led <= i_req.running;
        end
    end

    assign o_valid          = r_valid;
    assign o_segments       = r_seg;
    assign o_digit_enable_n = r_den;
    assign o_running_led    = r_led;

    `ASSERT_RST(a_one_digit, i_clk, i_rst_n, r_valid |-> $onehot(~r_den), "not exactly one digit enabled")
    `ASSERT_RST(a_dp_place, i_clk, i_rst_n, r_valid |-> (r_seg[7] == !r_den[1]), "decimal point on wrong digit")
    `ASSERT_RST(a_load_valid, i_clk, i_rst_n, i_load && o_can_load |=> r_valid, "loaded item not presented")

endmodule
